// ===== sv/lift_motor_limit_controller_core_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef LIFT_MOTOR_LIMIT_CONTROLLER_CORE_MACROS_SVH
`define LIFT_MOTOR_LIMIT_CONTROLLER_CORE_MACROS_SVH

`define LMLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define LMLC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/lmlc_pkg.sv =====
package lmlc_pkg;

    typedef enum logic [2:0] {
        MOT_STOP      = 3'd0,
        MOT_UP_FAST   = 3'd1,
        MOT_UP_SLOW   = 3'd2,
        MOT_DOWN_FAST = 3'd3,
        MOT_DOWN_SLOW = 3'd4
    } motion_t;

    typedef enum logic [1:0] {
        CFG_FAST_SPEED = 2'd0,
        CFG_SLOW_SPEED = 2'd1,
        CFG_SETTLE_MS  = 2'd2
    } cfg_index_t;

    localparam logic [7:0] FAST_SPEED_RESET = 8'd150;
    localparam logic [7:0] SLOW_SPEED_RESET = 8'd45;
    localparam logic [7:0] SETTLE_MS_RESET  = 8'd10;

    localparam logic [7:0] CMD_RELAY_ONE = 8'h41; // 'A'
    localparam logic [7:0] CMD_RELAY_TWO = 8'h42; // 'B'
    localparam logic [7:0] CMD_UP_FAST_A = 8'h55; // 'U'
    localparam logic [7:0] CMD_UP_FAST_B = 8'h4F; // 'O'
    localparam logic [7:0] CMD_UP_SLOW_A = 8'h75; // 'u'
    localparam logic [7:0] CMD_UP_SLOW_B = 8'h6F; // 'o'
    localparam logic [7:0] CMD_DN_FAST_A = 8'h44; // 'D'
    localparam logic [7:0] CMD_DN_FAST_B = 8'h43; // 'C'
    localparam logic [7:0] CMD_DN_SLOW_A = 8'h64; // 'd'
    localparam logic [7:0] CMD_DN_SLOW_B = 8'h63; // 'c'
    localparam logic [7:0] CMD_STOP      = 8'h53; // 'S'

    localparam int QUIET_W = 9;
    localparam logic [QUIET_W-1:0] QUIET_MAX = '1;

    typedef struct packed {
        logic       func;
        logic [7:0] cmd_byte;
        logic       top_pin_level;
        logic       bottom_pin_level;
    } item_t;

    typedef struct packed {
        logic [7:0] drive_up;
        logic [7:0] drive_down;
        logic       relay_one;
        logic       relay_two;
        logic [2:0] motion;
        logic       top_limit;
        logic       bottom_limit;
    } result_t;

endpackage

// ===== sv/lift_motor_limit_controller_core.sv =====
// Data path: an accepted item waits in the input register, its result is then loaded into
// the result register and transfers out from there (input and result registers).
// Throughput: one item per cycle; the item register holds while the result register
// is stalled and full.
// Reset (rst_n, async, active low): registers return to 150/45/10, stopped, relays on,
// limits released, quiet counters zero, both channels empty.
module lift_motor_limit_controller_core
    import lmlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

`include "lift_motor_limit_controller_core_macros.svh"

    logic [7:0] fast_speed_reg;
    logic [7:0] slow_speed_reg;
    logic [7:0] settle_ms_reg;

    logic       stage_valid_reg;
    item_t      stage_reg;
    logic       result_valid_reg;
    result_t    result_reg;
    result_t    result_next;

    motion_t    motion_reg;
    motion_t    motion_cmd;
    motion_t    motion_next;
    logic       relay_one_reg;
    logic       relay_one_next;
    logic       relay_two_reg;
    logic       relay_two_next;
    logic       top_next;
    logic       bottom_next;

    logic       advance;
    logic       accept;
    logic       tick;

    assign advance    = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = stage_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign tick       = advance && stage_reg.func;

    lmlc_debounce u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .pressed     (!stage_reg.top_pin_level),
        .settle_ms   (settle_ms_reg),
        .stable_next (top_next)
    );

    lmlc_debounce u_bottom
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .pressed     (!stage_reg.bottom_pin_level),
        .settle_ms   (settle_ms_reg),
        .stable_next (bottom_next)
    );

    always_comb
    begin
        motion_cmd     = motion_reg;
        relay_one_next = relay_one_reg;
        relay_two_next = relay_two_reg;
        if (!stage_reg.func)
        begin
            case (stage_reg.cmd_byte)
                CMD_RELAY_ONE: relay_one_next = !relay_one_reg;
                CMD_RELAY_TWO: relay_two_next = !relay_two_reg;
                CMD_UP_FAST_A,
                CMD_UP_FAST_B: motion_cmd = MOT_UP_FAST;
                CMD_UP_SLOW_A,
                CMD_UP_SLOW_B: motion_cmd = MOT_UP_SLOW;
                CMD_DN_FAST_A,
                CMD_DN_FAST_B: motion_cmd = MOT_DOWN_FAST;
                CMD_DN_SLOW_A,
                CMD_DN_SLOW_B: motion_cmd = MOT_DOWN_SLOW;
                CMD_STOP:      motion_cmd = MOT_STOP;
                default:       motion_cmd = motion_reg;
            endcase
        end

        motion_next            = motion_cmd;
        result_next.drive_up   = 8'd0;
        result_next.drive_down = 8'd0;
        case (motion_cmd)
            MOT_UP_FAST,
            MOT_UP_SLOW:
            begin
                if (top_next)
                begin
                    motion_next = MOT_STOP;
                end
                else
                begin
                    result_next.drive_up = (motion_cmd == MOT_UP_FAST) ?
                                           fast_speed_reg : slow_speed_reg;
                end
            end
            MOT_DOWN_FAST,
            MOT_DOWN_SLOW:
            begin
                if (bottom_next)
                begin
                    motion_next = MOT_STOP;
                end
                else
                begin
                    result_next.drive_down = (motion_cmd == MOT_DOWN_FAST) ?
                                             fast_speed_reg : slow_speed_reg;
                end
            end
            default: motion_next = MOT_STOP;
        endcase

        result_next.relay_one    = relay_one_next;
        result_next.relay_two    = relay_two_next;
        result_next.motion       = motion_next;
        result_next.top_limit    = top_next;
        result_next.bottom_limit = bottom_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_speed_reg   <= FAST_SPEED_RESET;
            slow_speed_reg   <= SLOW_SPEED_RESET;
            settle_ms_reg    <= SETTLE_MS_RESET;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            motion_reg       <= MOT_STOP;
            relay_one_reg    <= 1'b1;
            relay_two_reg    <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FAST_SPEED: fast_speed_reg <= cfg_data;
                    CFG_SLOW_SPEED: slow_speed_reg <= cfg_data;
                    CFG_SETTLE_MS:  settle_ms_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                motion_reg       <= motion_next;
                relay_one_reg    <= relay_one_next;
                relay_two_reg    <= relay_two_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `LMLC_ASSERT(a_one_drive, !(result_valid && result.drive_up != 8'd0 && result.drive_down != 8'd0), "both drive channels active")
    `LMLC_ASSERT_IMPL(a_top_stop, result_valid && result.top_limit, result.motion != MOT_UP_FAST && result.motion != MOT_UP_SLOW, "moving up at top limit")
    `LMLC_ASSERT_IMPL(a_bottom_stop, result_valid && result.bottom_limit, result.motion != MOT_DOWN_FAST && result.motion != MOT_DOWN_SLOW, "moving down at bottom limit")
    `LMLC_ASSERT_IMPL(a_result_load, advance, ##1 result_valid && result.motion == $past(motion_next), "result not loaded")
    `LMLC_ASSERT_IMPL(a_hold_stage, item_stall, stage_valid_reg && !accept, "stall without a held item")

endmodule

// ===== sv/lmlc_debounce.sv =====
module lmlc_debounce
    import lmlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic       pressed,
    input  logic [7:0] settle_ms,
    output logic       stable_next
);

    logic               stable_reg;
    logic [QUIET_W-1:0] count_reg;
    logic [QUIET_W-1:0] count_next;
    logic [QUIET_W-1:0] count_inc;

    always_comb
    begin
        count_inc   = (count_reg < QUIET_MAX) ? count_reg + 1'b1 : count_reg;
        stable_next = stable_reg;
        count_next  = count_reg;
        if (tick)
        begin
            count_next = count_inc;
            if (pressed != stable_reg)
            begin
                if (count_inc > {1'b0, settle_ms})
                begin
                    stable_next = pressed;
                end
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            stable_reg <= stable_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sim/lift_motor_limit_controller_core_tb.sv =====
module lift_motor_limit_controller_core_tb;
    import lmlc_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 40;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    item_t      item_data;
    logic       result_valid;
    logic       result_stall;
    result_t    result_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // model of the controller
    motion_t    mot;
    logic       rly_one;
    logic       rly_two;
    logic       top_st;
    logic       bot_st;
    logic [8:0] top_quiet;
    logic [8:0] bot_quiet;
    logic [7:0] fast_duty;
    logic [7:0] slow_duty;
    logic [7:0] deb_ms;

    result_t    exp_q[$];
    int         errors = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    bit         steady = 1'b0;
    bit         hold_req = 1'b0;
    logic       gen_top = 1'b1;
    logic       gen_bot = 1'b1;

    logic [7:0] cmd_set [11] = '{CMD_RELAY_ONE, CMD_RELAY_TWO, CMD_UP_FAST_A, CMD_UP_FAST_B,
                                 CMD_UP_SLOW_A, CMD_UP_SLOW_B, CMD_DN_FAST_A, CMD_DN_FAST_B,
                                 CMD_DN_SLOW_A, CMD_DN_SLOW_B, CMD_STOP};

    lift_motor_limit_controller_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // returns {stable, quiet}
    function automatic logic [9:0] debounce_next(logic raw, logic st, logic [8:0] q);
        logic [8:0] nq;
        logic       ns;
        nq = (q != QUIET_MAX) ? q + 9'd1 : q;
        ns = st;
        if (raw != st)
        begin
            if (nq > {1'b0, deb_ms})
                ns = raw;
            nq = '0;
        end
        return {ns, nq};
    endfunction

    function automatic result_t lift_step(item_t it);
        result_t    r;
        logic [9:0] d;
        if (!it.func)
        begin
            case (it.cmd_byte)
                CMD_RELAY_ONE:                rly_one = ~rly_one;
                CMD_RELAY_TWO:                rly_two = ~rly_two;
                CMD_UP_FAST_A, CMD_UP_FAST_B: mot = MOT_UP_FAST;
                CMD_UP_SLOW_A, CMD_UP_SLOW_B: mot = MOT_UP_SLOW;
                CMD_DN_FAST_A, CMD_DN_FAST_B: mot = MOT_DOWN_FAST;
                CMD_DN_SLOW_A, CMD_DN_SLOW_B: mot = MOT_DOWN_SLOW;
                CMD_STOP:                     mot = MOT_STOP;
                default: ;
            endcase
        end
        else
        begin
            d = debounce_next(~it.top_pin_level, top_st, top_quiet);
            top_st = d[9];
            top_quiet = d[8:0];
            d = debounce_next(~it.bottom_pin_level, bot_st, bot_quiet);
            bot_st = d[9];
            bot_quiet = d[8:0];
        end
        r = '0;
        case (mot)
            MOT_UP_FAST, MOT_UP_SLOW:
            begin
                if (top_st)
                    mot = MOT_STOP;
                else
                    r.drive_up = (mot == MOT_UP_FAST) ? fast_duty : slow_duty;
            end
            MOT_DOWN_FAST, MOT_DOWN_SLOW:
            begin
                if (bot_st)
                    mot = MOT_STOP;
                else
                    r.drive_down = (mot == MOT_DOWN_FAST) ? fast_duty : slow_duty;
            end
            default: mot = MOT_STOP;
        endcase
        r.relay_one = rly_one;
        r.relay_two = rly_two;
        r.motion = mot;
        r.top_limit = top_st;
        r.bottom_limit = bot_st;
        return r;
    endfunction

    function automatic item_t cmd_item(logic [7:0] c);
        item_t it;
        it.func = 1'b0;
        it.cmd_byte = c;
        it.top_pin_level = 1'($urandom_range(0, 1));
        it.bottom_pin_level = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic item_t tick_item(logic top_pin, logic bot_pin, logic [7:0] junk);
        item_t it;
        it.func = 1'b1;
        it.cmd_byte = junk;
        it.top_pin_level = top_pin;
        it.bottom_pin_level = bot_pin;
        return it;
    endfunction

    // pin levels held in runs so that the debounce gets quiet time
    function automatic item_t rand_item();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
        begin
            if ($urandom_range(0, 9) == 0)
                gen_top = ~gen_top;
            if ($urandom_range(0, 9) == 0)
                gen_bot = ~gen_bot;
            return tick_item(gen_top, gen_bot, 8'($urandom));
        end
        else if (k < 90)
            return cmd_item(cmd_set[4'($urandom_range(0, 10))]);
        else
            return cmd_item(8'($urandom));
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            @(negedge clk) item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_data <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!(item_valid && !item_stall));
        exp_q.push_back(lift_step(it));
        items_sent++;
    endtask

    task automatic wait_drain();
        @(negedge clk) item_valid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_FAST_SPEED: fast_duty = val;
            CFG_SLOW_SPEED: slow_duty = val;
            CFG_SETTLE_MS:  deb_ms = val;
            default: ;
        endcase
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] f, input logic [7:0] s, input logic [7:0] d);
        wait_drain();
        write_reg(CFG_FAST_SPEED, f);
        write_reg(CFG_SLOW_SPEED, s);
        write_reg(CFG_SETTLE_MS, d);
    endtask

    task automatic test_directed_commands();
        send_item(cmd_item(CMD_UP_FAST_A));
        send_item(cmd_item(CMD_UP_SLOW_A));
        send_item(cmd_item(CMD_RELAY_ONE));
        send_item(cmd_item(CMD_RELAY_TWO));
        send_item(cmd_item(CMD_RELAY_ONE));
        send_item(cmd_item(CMD_DN_FAST_A));
        send_item(cmd_item(CMD_DN_SLOW_A));
        send_item(cmd_item(CMD_UP_FAST_B));
        send_item(cmd_item(CMD_UP_SLOW_B));
        send_item(cmd_item(CMD_DN_FAST_B));
        send_item(cmd_item(CMD_DN_SLOW_B));
        send_item(tick_item(1'b1, 1'b1, 8'hFF));
        send_item(cmd_item(8'h00));
        send_item(cmd_item(8'hFF));
        send_item(cmd_item(CMD_STOP));
        // zero debounce: any differing sample is taken at once
        set_regs(8'hFF, 8'h00, 8'h00);
        send_item(cmd_item(CMD_UP_FAST_A));
        send_item(tick_item(1'b0, 1'b1, 8'h00));
        send_item(cmd_item(CMD_UP_SLOW_A));
        send_item(cmd_item(CMD_DN_SLOW_A));
        send_item(tick_item(1'b0, 1'b0, 8'hAA));
        send_item(tick_item(1'b1, 1'b1, 8'h55));
        send_item(cmd_item(CMD_DN_FAST_B));
        send_item(cmd_item(CMD_UP_SLOW_B));
    endtask

    task automatic test_config_extremes();
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: set_regs(8'hFF, 8'h00, 8'h00);
                1: set_regs(8'h00, 8'hFF, 8'h01);
                2: set_regs(8'h01, 8'hFE, 8'h02);
                3:
                begin
                    set_regs(8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)));
                    write_reg(CFG_UNUSED, 8'($urandom));
                end
                default: set_regs(8'h80, 8'h7F, 8'h05);
            endcase
            repeat (100) send_item(rand_item());
        end
    endtask

    // quiet counters run into saturation with the longest debounce time
    task automatic test_quiet_saturation();
        set_regs(8'hC3, 8'h3C, 8'h00);
        send_item(tick_item(1'b1, 1'b1, 8'($urandom)));
        set_regs(8'hC3, 8'h3C, 8'hFF);
        repeat (520) send_item(tick_item(1'b1, 1'b1, 8'($urandom)));
        send_item(tick_item(1'b0, 1'b1, 8'($urandom)));
        send_item(cmd_item(CMD_UP_FAST_A));
        repeat (100) send_item(tick_item(1'b0, 1'b1, 8'($urandom)));
        send_item(tick_item(1'b1, 1'b1, 8'($urandom)));
        send_item(cmd_item(CMD_UP_SLOW_A));
        send_item(cmd_item(CMD_DN_FAST_A));
    endtask

    task automatic test_backpressure();
        set_regs(8'hC8, 8'h3C, 8'h03);
        hold_req = 1'b1;
        repeat (30) send_item(rand_item());
        wait_drain();
    endtask

    task automatic test_steady_stream();
        set_regs(FAST_SPEED_RESET, SLOW_SPEED_RESET, 8'h04);
        steady = 1'b1;
        repeat (100) send_item(rand_item());
        wait_drain();
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (exp_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer at %0t", $realtime);
            end
            else
            begin
                want = exp_q.pop_front();
                results_seen++;
                if (want.drive_up !== result_data.drive_up
                    || want.drive_down !== result_data.drive_down
                    || want.relay_one !== result_data.relay_one
                    || want.relay_two !== result_data.relay_two
                    || want.motion !== result_data.motion
                    || want.top_limit !== result_data.top_limit
                    || want.bottom_limit !== result_data.bottom_limit)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch on result %0d at %0t", results_seen, $realtime);
                        $display("  exp up=%0d dn=%0d r1=%0b r2=%0b mot=%0d top=%0b bot=%0b",
                                 want.drive_up, want.drive_down, want.relay_one,
                                 want.relay_two, want.motion, want.top_limit,
                                 want.bottom_limit);
                        $display("  got up=%0d dn=%0d r1=%0b r2=%0b mot=%0d top=%0b bot=%0b",
                                 result_data.drive_up, result_data.drive_down,
                                 result_data.relay_one, result_data.relay_two,
                                 result_data.motion, result_data.top_limit,
                                 result_data.bottom_limit);
                    end
                end
            end
        end
    end

    initial
    begin : receiver
        int w;
        forever
        begin
            do @(posedge clk); while (!(result_valid && !result_stall) && !hold_req);
            if (hold_req)
            begin
                hold_req = 1'b0;
                w = HOLD_CYCLES;
            end
            else
                w = steady ? 0 : $urandom_range(0, 3);
            if (w > 0)
            begin
                @(negedge clk) result_stall <= 1'b1;
                repeat (w - 1) @(negedge clk);
                @(negedge clk) result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_data = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mot = MOT_STOP;
        rly_one = 1'b1;
        rly_two = 1'b1;
        top_st = 1'b0;
        bot_st = 1'b0;
        top_quiet = '0;
        bot_quiet = '0;
        fast_duty = FAST_SPEED_RESET;
        slow_duty = SLOW_SPEED_RESET;
        deb_ms = SETTLE_MS_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_directed_commands();
        test_config_extremes();
        test_quiet_saturation();
        test_backpressure();
        test_steady_stream();

        wait_drain();
        repeat (4) @(posedge clk);
        $display("covered: all commands, ignored bytes, limit stops, debounce at 0..255 ms");
        $display("with counter saturation, stalls on both sides; %0d transfers, %0d checked",
                 items_sent, results_seen);
        if (errors == 0 && exp_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
